### rtl/cpd_pkg.sv
// Shared types and constants for the column prime detector.
// Used by cpd_divider, cpd_trial and column_prime_detector_unit; no dependencies.
package cpd_pkg;

  // Columns at or beyond this index are never tested.
  localparam int MAX_COLUMNS = 16;
  localparam logic [8:0] COL_LIMIT = 9'(MAX_COLUMNS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_BOUND,
    T_DIV,
    T_DONE
  } trial_state_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic prime;
  } trial_stat_t;

endpackage

### rtl/cpd_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on cpd_pkg for the status struct.
module cpd_divider import cpd_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] shift;
  logic [VALUE_BITS-1:0] rem;
  logic [VALUE_BITS-1:0] dsr;
  logic [VALUE_BITS:0]   partial;
  logic [VALUE_BITS:0]   diff;
  logic [VALUE_BITS-1:0] rem_next;

  always_comb begin
    partial  = {rem, shift[VALUE_BITS-1]};
    diff     = partial - {1'b0, dsr};
    rem_next = diff[VALUE_BITS] ? partial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload: shift the dividend out MSB first, fold each bit into the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      dsr   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shift <= {shift[VALUE_BITS-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign stat.done     = done;
  assign stat.rem_zero = (rem == '0);

endmodule

### rtl/cpd_trial.sv
// Trial-division sequencer: steps divisors 2, 3, ... while d*d <= value.
// Depends on cpd_pkg and uses cpd_divider for each remainder.
module cpd_trial import cpd_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output trial_stat_t           stat
);

  trial_state_t          state;
  trial_state_t          state_next;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS:0]   d_sq;
  logic                  prime;
  logic                  too_small;
  logic                  past_bound;
  logic                  div_start;
  div_stat_t             div_stat;

  assign too_small  = value[VALUE_BITS-1] || (value < VALUE_BITS'(2));
  assign past_bound = d_sq > {1'b0, val};

  cpd_divider #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (val),
    .divisor  (d),
    .stat     (div_stat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  if (start) state_next = too_small ? T_DONE : T_BOUND;
      T_BOUND: state_next = past_bound ? T_DONE : T_DIV;
      T_DIV: begin
        if (div_stat.done) state_next = div_stat.rem_zero ? T_DONE : T_BOUND;
      end
      T_DONE:  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    div_start  = 1'b0;
    stat.busy  = 1'b1;
    stat.done  = 1'b0;
    stat.prime = prime;
    unique case (state)
      T_IDLE:  stat.busy = 1'b0;
      T_BOUND: div_start = !past_bound;
      T_DIV:   ;
      T_DONE:  stat.done = 1'b1;
      default: stat.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      prime <= 1'b0;
    end else begin
      state <= state_next;
      if (state == T_IDLE && start) begin
        prime <= 1'b0;
      end else if (state == T_BOUND && past_bound) begin
        prime <= 1'b1;
      end
    end
  end

  // Advance d and (d+1)^2 = d^2 + 2d + 1 after each nonzero remainder.
  always_ff @(posedge clk) begin
    if (state == T_IDLE && start) begin
      val  <= value;
      d    <= VALUE_BITS'(2);
      d_sq <= (VALUE_BITS + 1)'(4);
    end else if (state == T_DIV && div_stat.done) begin
      d    <= d + 1'b1;
      d_sq <= d_sq + {d, 1'b1};
    end
  end

endmodule

### rtl/column_prime_detector_unit.sv
// Column prime detector top level: handshakes, watched-column register, sticky flag.
// Depends on cpd_pkg; instantiates cpd_trial (which holds cpd_divider).
//
// Usage: matrix elements arrive on the input channel (in_valid / in_stall) in
// row-major order with their column index and a last-element flag. Elements of
// the watched column get a trial-division primality test; after the element
// flagged last, one beat leaves on the output channel (out_valid / out_stall)
// telling whether any tested element since the previous report was prime.
// Throughput: one element at a time. An untested element is taken without a
// stall; for a tested value v the input stalls while trial divisors run one
// after another through the bit-serial remainder unit, up to floor(sqrt(v)) - 1
// of them. A report passes through the emit state into the output register.
// The output register parts the channels: new elements are taken while a
// report waits; a second report waits until the first beat is taken.
// watched_column is written through cfg_valid / cfg_ready / cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// Synchronous reset clears the flag, the output beat and watched_column to 0.
module column_prime_detector_unit import cpd_pkg::*; #(
  parameter int VALUE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [3:0]                   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [VALUE_BITS-1:0] element_value,
  input  logic [3:0]                   element_column,
  input  logic                         last_element,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         column_has_prime
);

  top_state_t  state;
  top_state_t  state_next;
  logic [3:0]  watched_column;
  logic        last_pend;
  logic        prime_seen;
  logic        accept;
  logic        test_it;
  logic        trial_start;
  logic        load_out;
  trial_stat_t trial_stat;

  assign cfg_ready = 1'b1;
  assign test_it   = ({5'b0, element_column} < COL_LIMIT) &&
                     (element_column == watched_column);

  cpd_trial #(.VALUE_BITS(VALUE_BITS)) u_trial (
    .clk   (clk),
    .rst   (rst),
    .start (trial_start),
    .value (element_value),
    .stat  (trial_stat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (test_it) state_next = S_BUSY;
          else if (last_element) state_next = S_EMIT;
        end
      end
      S_BUSY: begin
        if (trial_stat.done) state_next = last_pend ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    trial_start = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall    = 1'b0;
        trial_start = in_valid && test_it;
      end
      S_BUSY: ;
      S_EMIT: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      watched_column <= 4'd0;
      last_pend      <= 1'b0;
      prime_seen     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) watched_column <= cfg_data;
      if (accept) last_pend <= last_element;
      // Report and clear the flag in one step.
      if (load_out) begin
        prime_seen <= 1'b0;
      end else if (trial_stat.done && trial_stat.prime) begin
        prime_seen <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) column_has_prime <= prime_seen;
  end

  a_trial_start_idle: assert property (@(posedge clk) disable iff (rst)
    trial_start |-> !trial_stat.busy)
    else $error("trial started while a test is running");

  a_trial_done_busy: assert property (@(posedge clk) disable iff (rst)
    trial_stat.done |-> state == S_BUSY)
    else $error("trial finished with no element waiting on it");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    trial_stat.busy |-> in_stall)
    else $error("input taken during a primality test");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && !prime_seen)
    else $error("report did not load the output or clear the flag");

endmodule

### tb/tb_column_prime_detector_unit.sv
// Self-checking testbench for column_prime_detector_unit: matrices in row-major order,
// watched-column sweeps, random input gaps and random output stalls, checked against a scoreboard.
// Depends on cpd_pkg and the column_prime_detector_unit RTL.
`timescale 1ns / 100ps

module tb_column_prime_detector_unit;
  import cpd_pkg::MAX_COLUMNS;

  localparam int VALUE_BITS = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int PHASE_ITEMS = 40;
  localparam int SETTLE_CYCLES = 3600;

  // Sticky prime flag for the watched column plus the reports it owes.
  class prime_report_board;
    logic [3:0] watched_column;
    bit prime_seen;
    logic pending_reports[$];
    int unsigned failures;

    function new();
      watched_column = '0;
      prime_seen = 1'b0;
      failures = 0;
    endfunction

    function void set_watch(logic [3:0] col);
      watched_column = col;
    endfunction

    static function bit element_is_prime(logic signed [VALUE_BITS-1:0] value);
      int n;
      n = value;
      if (n < 2) return 1'b0;
      for (int d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_element(logic signed [VALUE_BITS-1:0] value, logic [3:0] column,
                               logic last);
      if (int'(column) < MAX_COLUMNS && column == watched_column &&
          element_is_prime(value))
        prime_seen = 1'b1;
      if (last) begin
        pending_reports.push_back(prime_seen);
        prime_seen = 1'b0;
      end
    endfunction

    function void check_report(logic got);
      logic want;
      if (pending_reports.size() == 0) begin
        $error("column_has_prime: no report expected, got %0b", got);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          $error("column_has_prime: expected %0b, got %0b", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VALUE_BITS-1:0] element_value = '0;
  logic [3:0] element_column = '0;
  logic last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic column_has_prime;

  prime_report_board board = new();
  bit sender_calm = 1'b0;
  int unsigned random_items = 0;
  int unsigned stall_left = 0;

  column_prime_detector_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element_value(element_value),
    .element_column(element_column),
    .last_element(last_element),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .column_has_prime(column_has_prime)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 300);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int unsigned r;
    logic signed [VALUE_BITS-1:0] v;
    r = $urandom_range(0, 99);
    v = VALUE_BITS'($urandom);
    if (r < 30) begin
      v = VALUE_BITS'($urandom_range(0, 200));
    end else if (r < 45) begin
      v[VALUE_BITS-1] = 1'b1;
    end else if (r >= 85) begin
      // squares of primes, among them the smallest and the largest that fit
      case ($urandom_range(0, 5))
        0: v = 16'sd4;
        1: v = 16'sd9;
        2: v = 16'sd49;
        3: v = 16'sd961;
        4: v = 16'sd32041;
        default: v = 16'sd32761;
      endcase
    end else if (r >= 70) begin
      case ($urandom_range(0, 4))
        0: v = 16'sd32749;
        1: v = 16'sd32719;
        2: v = 16'sd32717;
        3: v = 16'sd30011;
        default: v = 16'sd32399;
      endcase
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      board.note_element(element_value, element_column, last_element);
    if (!rst && out_valid && !out_stall)
      board.check_report(column_has_prime);
  end

  // Receiver stall pattern, with occasional long stall-free stretches.
  always @(posedge clk) begin
    int unsigned len;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(200, 1500)
                                                 : $urandom_range(0, 6);
    end else begin
      len = gap_len();
      out_stall <= (len != 0);
      stall_left <= len;
    end
  end

  task automatic send_element(input logic signed [VALUE_BITS-1:0] value,
                              input logic [3:0] column, input logic last);
    int unsigned len;
    in_valid <= 1'b1;
    element_value <= value;
    element_column <= column;
    last_element <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    len = gap_len();
    if (!sender_calm && len != 0) begin
      in_valid <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_watch(input logic [3:0] col);
    cfg_valid <= 1'b1;
    cfg_data <= col;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_watch(col);
  endtask

  task automatic run_phase(input logic [3:0] watch, input bit pause_once);
    int unsigned sent;
    int unsigned rows;
    int unsigned cols;
    int unsigned top;
    bit done;
    logic last;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        // stray beat: any column, any last flag
        send_element(pick_value(), 4'($urandom), $urandom_range(0, 3) == 0);
        sent++;
      end else begin
        rows = $urandom_range(1, 3);
        top = (watch + 3 > 16) ? 16 : watch + 3;
        cols = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(watch + 1, top);
        done = 1'b0;
        for (int r = 0; r < rows; r++) begin
          for (int c = 0; c < cols; c++) begin
            if (!done) begin
              last = (r == rows - 1 && c == cols - 1);
              // cut the matrix short now and then
              if ($urandom_range(0, 49) == 0) last = 1'b1;
              send_element(pick_value(), 4'(c), last);
              sent++;
              done = last;
            end
          end
        end
        if (pause_once) begin
          wait_drained();
          pause_once = 1'b0;
        end
      end
    end
    random_items += sent;
  endtask

  initial begin : stimulus
    int unsigned phase;
    logic [3:0] watch;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_watch(4'd0);

    send_element(16'sd0, 4'd3, 1'b1);
    send_element(16'sd4, 4'd0, 1'b0);
    send_element(16'sd1, 4'd0, 1'b0);
    send_element(16'sd0, 4'd0, 1'b0);
    send_element(-16'sd1, 4'd0, 1'b0);
    send_element(16'sh8000, 4'd0, 1'b0);
    send_element(16'sd32767, 4'd0, 1'b1);
    send_element(16'sd2, 4'd0, 1'b1);
    send_element(16'sd7, 4'd5, 1'b0);
    send_element(16'sd9, 4'd0, 1'b0);
    send_element(16'sd25, 4'd0, 1'b0);
    send_element(16'sd32761, 4'd0, 1'b1);
    send_element(16'sd32749, 4'd0, 1'b0);
    send_element(16'sd3, 4'd15, 1'b1);
    send_element(-16'sd3, 4'd0, 1'b1);
    send_element(16'sd5, 4'd15, 1'b0);
    send_element(-16'sd7, 4'd0, 1'b1);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      // let the block finish any trailing trial before touching the register
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (phase)
        0: watch = 4'd15;
        1: watch = 4'd7;
        2: watch = 4'd0;
        3: watch = 4'd12;
        4: watch = 4'd1;
        default: watch = 4'($urandom);
      endcase
      write_watch(watch);
      sender_calm = (phase == 2);
      run_phase(watch, phase == 1);
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.pending_reports.size() != 0) begin
      $error("column_has_prime: %0d reports never arrived", board.pending_reports.size());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("tb_column_prime_detector_unit: PASS");
    end else begin
      $display("tb_column_prime_detector_unit: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_column_prime_detector_unit: FAIL");
    $finish;
  end

endmodule
